>>> rtl/core/dbf_pkg.sv
package dbf_pkg;

    // symbol codes on the kind input
    localparam logic [2:0] KIND_DOT    = 3'd0;
    localparam logic [2:0] KIND_OPEN   = 3'd1;
    localparam logic [2:0] KIND_CLOSE  = 3'd2;
    localparam logic [2:0] KIND_ANCHOR = 3'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TOTAL_NODES = 2'd0;
    localparam logic [1:0] CFG_ANCHORED    = 2'd1;
    localparam logic [1:0] CFG_USE_BASES   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

    localparam logic [7:0] CHAR_P = 8'h50;
    localparam logic [7:0] CHAR_B = 8'h42;

    localparam int DEF_MAX_DEPTH = 64;
    localparam int DEF_NODE_BITS = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    typedef enum logic [1:0]
    {
        OP_DOT,
        OP_OPEN,
        OP_CLOSE,
        OP_ANCHOR
    } op_t;

    typedef struct packed
    {
        op_t        op;
        logic [7:0] leaf;
    } cmd_t;

    typedef struct packed
    {
        logic [15:0] total_nodes;
        logic        anchored_mode;
        logic        use_bases;
    } cfg_t;

    typedef struct packed
    {
        logic [15:0] node_index;
        logic        label_valid;
        logic [7:0]  label;
        logic        links_valid;
        logic [15:0] right_sibling;
        logic [15:0] child_count;
        logic        anchor_valid;
        logic [15:0] anchor_number;
        logic [1:0]  error;
        logic        last;
    } rec_t;

endpackage

>>> rtl/core/dbf_front.sv
// Symbol classifier: drops ignored symbols, resolves the leaf label.
module dbf_front
(
    input  logic [2:0]    kind,
    input  logic [7:0]    base_char,
    input  dbf_pkg::cfg_t cfg,
    output logic          keep,
    output dbf_pkg::cmd_t cmd
);

    always_comb
    begin
        keep     = 1'b1;
        cmd.op   = dbf_pkg::OP_DOT;
        cmd.leaf = cfg.use_bases ? base_char : dbf_pkg::CHAR_B;
        case (kind)
            dbf_pkg::KIND_DOT:    cmd.op = dbf_pkg::OP_DOT;
            dbf_pkg::KIND_OPEN:   cmd.op = dbf_pkg::OP_OPEN;
            dbf_pkg::KIND_CLOSE:  cmd.op = dbf_pkg::OP_CLOSE;
            dbf_pkg::KIND_ANCHOR:
            begin
                cmd.op = dbf_pkg::OP_ANCHOR;
                keep   = cfg.anchored_mode;
            end
            default:              keep = 1'b0;
        endcase
    end

endmodule

>>> rtl/core/dbf_queue.sv
// Small command queue between classifier and executor.
module dbf_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dbf_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output dbf_pkg::cmd_t pop_data,
    output logic          empty
);

    dbf_pkg::cmd_t                  slot_reg [dbf_pkg::QUEUE_DEPTH];
    logic [dbf_pkg::QUEUE_AW-1:0]   head_reg;
    logic [dbf_pkg::QUEUE_AW-1:0]   tail_reg;
    logic [dbf_pkg::QUEUE_CW-1:0]   count_reg;

    assign full     = count_reg == dbf_pkg::QUEUE_CW'(dbf_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = slot_reg[head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/dbf_back.sv
// Executor: bracket stack, node and anchor counters, record output.
module dbf_back
#(
    parameter int MAX_DEPTH = dbf_pkg::DEF_MAX_DEPTH,
    parameter int NODE_BITS = dbf_pkg::DEF_NODE_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  dbf_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  dbf_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output dbf_pkg::rec_t out_rec
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef struct packed
    {
        logic [NODE_BITS-1:0] pair;
        logic [15:0]          cc;
    } frame_t;

    frame_t               stack_mem [MAX_DEPTH];
    frame_t               top_reg;
    frame_t               below_reg;
    logic [DW-1:0]        depth_reg;
    logic [DW-1:0]        depth_next;
    logic [NODE_BITS-1:0] next_node_reg;
    logic [NODE_BITS-1:0] next_node_next;
    logic [15:0]          next_anchor_reg;
    logic [15:0]          next_anchor_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    dbf_pkg::rec_t        out_rec_reg;
    dbf_pkg::rec_t        pend_rec_reg;

    logic                 can_load;
    logic                 exec;
    logic                 at_top;
    logic                 at_floor;
    logic                 do_push;
    logic                 do_pop;
    logic [NODE_BITS-1:0] node;
    logic [NODE_BITS-1:0] nxt;
    logic [NODE_BITS-1:0] nxt2;
    logic [NODE_BITS-1:0] last_idx;
    logic [NODE_BITS-1:0] rs_tail;
    logic [DW-1:0]        rd_sum;
    frame_t               push_frame;
    dbf_pkg::rec_t        rec0;
    dbf_pkg::rec_t        rec1;
    logic                 two;

    assign can_load   = !out_valid_reg || !out_stall;
    assign exec       = can_load && !pend_valid_reg && !q_empty;
    assign q_pop      = exec;
    assign node       = next_node_reg;
    assign nxt        = node + 1'b1;
    assign nxt2       = node + NODE_BITS'(2);
    // total_nodes of zero makes the all-ones index the last one
    assign last_idx   = NODE_BITS'(cfg.total_nodes) - 1'b1;
    assign rs_tail    = (node == last_idx) ? '0 : nxt;
    assign at_top     = depth_reg == DW'(MAX_DEPTH);
    assign at_floor   = depth_reg == '0;
    assign do_push    = exec && (q_cmd.op == dbf_pkg::OP_OPEN) && !at_top;
    assign do_pop     = exec && (q_cmd.op == dbf_pkg::OP_CLOSE) && !at_floor;
    assign rd_sum     = depth_reg - DW'(2);
    assign push_frame = '{pair: top_reg.pair, cc: top_reg.cc + 16'd1};

    always_comb
    begin
        rec0             = '0;
        rec1             = '0;
        two              = 1'b0;
        rec0.node_index  = 16'(node);
        depth_next       = depth_reg;
        next_node_next   = next_node_reg;
        next_anchor_next = next_anchor_reg;
        case (q_cmd.op)
            dbf_pkg::OP_DOT:
            begin
                rec0.label_valid   = 1'b1;
                rec0.label         = q_cmd.leaf;
                rec0.links_valid   = 1'b1;
                rec0.right_sibling = 16'(rs_tail);
                rec0.last          = 1'b1;
                next_node_next     = nxt;
            end
            dbf_pkg::OP_OPEN:
            begin
                if (at_top)
                begin
                    rec0.error = dbf_pkg::ERR_OVERFLOW;
                    rec0.last  = 1'b1;
                end
                else
                begin
                    two                = 1'b1;
                    rec0.label_valid   = 1'b1;
                    rec0.label         = dbf_pkg::CHAR_P;
                    rec1.node_index    = 16'(nxt);
                    rec1.label_valid   = 1'b1;
                    rec1.label         = q_cmd.leaf;
                    rec1.links_valid   = 1'b1;
                    rec1.right_sibling = 16'(nxt2);
                    rec1.last          = 1'b1;
                    depth_next         = depth_reg + 1'b1;
                    next_node_next     = nxt2;
                end
            end
            dbf_pkg::OP_CLOSE:
            begin
                if (at_floor)
                begin
                    rec0.error = dbf_pkg::ERR_UNDERFLOW;
                    rec0.last  = 1'b1;
                end
                else
                begin
                    two                = 1'b1;
                    rec0.label_valid   = 1'b1;
                    rec0.label         = q_cmd.leaf;
                    rec0.links_valid   = 1'b1;
                    rec1.node_index    = 16'(top_reg.pair);
                    rec1.links_valid   = 1'b1;
                    rec1.right_sibling = 16'(rs_tail);
                    rec1.child_count   = top_reg.cc + 16'd1;
                    rec1.last          = 1'b1;
                    depth_next         = depth_reg - 1'b1;
                    next_node_next     = nxt;
                end
            end
            dbf_pkg::OP_ANCHOR:
            begin
                rec0.anchor_valid  = 1'b1;
                rec0.anchor_number = next_anchor_reg;
                rec0.last          = 1'b1;
                next_anchor_next   = next_anchor_reg + 16'd1;
            end
            default:
            begin
                rec0 = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        if (can_load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next  = exec;
                pend_valid_next = exec && two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            depth_reg       <= '0;
            next_node_reg   <= '0;
            next_anchor_reg <= 16'd1;
            top_reg         <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (exec)
            begin
                depth_reg       <= depth_next;
                next_node_reg   <= next_node_next;
                next_anchor_reg <= next_anchor_next;
            end
            if (do_push)
            begin
                top_reg.pair <= node;
                top_reg.cc   <= 16'd1;
            end
            else if (do_pop)
            begin
                top_reg <= below_reg;
            end
            else if (exec && (q_cmd.op == dbf_pkg::OP_DOT))
            begin
                top_reg.cc <= top_reg.cc + 16'd1;
            end
        end
    end

    // payload: records
    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            if (pend_valid_reg)
            begin
                out_rec_reg <= pend_rec_reg;
            end
            else if (exec)
            begin
                out_rec_reg  <= rec0;
                pend_rec_reg <= rec1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_mem[depth_reg[AW-1:0]] <= push_frame;
            below_reg                    <= push_frame;
        end
        else if (do_pop && (depth_reg > DW'(1)))
        begin
            below_reg <= stack_mem[rd_sum[AW-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("second record pending without a first record held");

    a_pend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> pend_rec_reg.last)
        else $error("pending record is not the final one");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(MAX_DEPTH))
        else $error("bracket depth beyond limit");

    a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> depth_reg == $past(depth_reg) + 1'b1)
        else $error("push did not raise depth");

    a_no_exec_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && out_stall) |=> pend_valid_reg && $stable(pend_rec_reg))
        else $error("pending record lost under stall");

endmodule

>>> rtl/core/dot_bracket_forest_builder.sv
// Dot-bracket forest builder. Each input request carries one structure symbol
// (kind) and its base; the block answers with preorder node records on the
// output channel, one record per cycle at most. A dot gives one record, an
// opening or closing bracket two (pair node then leaf, or leaf then the patched
// pair node), an anchor symbol one in anchored mode; ignored symbols give none.
// A bracket that would overflow or underflow the stack gives one error record.
// The input takes one request per cycle while the four-entry command queue has
// room. The executor takes no new command while the second record of an
// accepted bracket waits behind the single-record output register; ignored
// symbols never reach the executor; a stalled output only backs up into
// the queue. The bracket stack keeps its top frame in registers and the
// frame below it in a registered read of the stack memory, so nested pops
// follow each other without a bubble. Configuration writes are always ready
// and must only be made while no request is in flight.
module dot_bracket_forest_builder
#(
    parameter int MAX_DEPTH = dbf_pkg::DEF_MAX_DEPTH,
    parameter int NODE_BITS = dbf_pkg::DEF_NODE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input requests
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  base_char,
    // node records
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] node_index,
    output logic        label_valid,
    output logic [7:0]  label,
    output logic        links_valid,
    output logic [15:0] right_sibling,
    output logic [15:0] child_count,
    output logic        anchor_valid,
    output logic [15:0] anchor_number,
    output logic [1:0]  error,
    output logic        last
);

    dbf_pkg::cfg_t cfg_reg;
    dbf_pkg::cmd_t front_cmd;
    dbf_pkg::cmd_t q_cmd;
    dbf_pkg::rec_t rec;
    logic          front_keep;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic          q_push;

    // configuration registers, written at any time the port is offered a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_nodes   <= 16'd1;
            cfg_reg.anchored_mode <= 1'b0;
            cfg_reg.use_bases     <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dbf_pkg::CFG_TOTAL_NODES: cfg_reg.total_nodes   <= cfg_data;
                dbf_pkg::CFG_ANCHORED:    cfg_reg.anchored_mode <= cfg_data[0];
                dbf_pkg::CFG_USE_BASES:   cfg_reg.use_bases     <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // front: classify; ignored symbols are accepted and dropped here
    dbf_front u_front
    (
        .kind      (kind),
        .base_char (base_char),
        .cfg       (cfg_reg),
        .keep      (front_keep),
        .cmd       (front_cmd)
    );

    assign in_stall = q_full;
    assign q_push   = in_valid && !in_stall && front_keep;

    dbf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_cmd),
        .empty     (q_empty)
    );

    // back: stack, counters and the output record register
    dbf_back
    #(
        .MAX_DEPTH (MAX_DEPTH),
        .NODE_BITS (NODE_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rec   (rec)
    );

    assign node_index    = rec.node_index;
    assign label_valid   = rec.label_valid;
    assign label         = rec.label;
    assign links_valid   = rec.links_valid;
    assign right_sibling = rec.right_sibling;
    assign child_count   = rec.child_count;
    assign anchor_valid  = rec.anchor_valid;
    assign anchor_number = rec.anchor_number;
    assign error         = rec.error;
    assign last          = rec.last;

endmodule

>>> verif/tb_dot_bracket_forest_builder.sv
`timescale 1ns / 1ps

module tb_dot_bracket_forest_builder;

    // kind values with the top bit set are spare symbols the block drops
    localparam logic [2:0] KIND_FIRST_IGNORED = 3'd4;
    // register index with nothing behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int STACK_TOP    = dbf_pkg::DEF_MAX_DEPTH;
    localparam int DRAIN_LIMIT  = 4000;  // cycles to wait for outstanding records
    localparam int TAIL_CYCLES  = 16;    // cmd queue + output reg
    localparam int WRAP_PAIRS   = 40;    // dot and anchor pairs inside the long pair

    typedef struct packed
    {
        logic [2:0] sym;
        logic [7:0] base;
    } sym_req_t;

    // ---------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ---------------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = dbf_pkg::CFG_TOTAL_NODES;
    logic [15:0] cfg_data  = 16'h0000;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [2:0]  kind      = dbf_pkg::KIND_DOT;
    logic [7:0]  base_char = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] node_index;
    logic        label_valid;
    logic [7:0]  label;
    logic        links_valid;
    logic [15:0] right_sibling;
    logic [15:0] child_count;
    logic        anchor_valid;
    logic [15:0] anchor_number;
    logic [1:0]  error;
    logic        last;

    dot_bracket_forest_builder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .base_char     (base_char),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .node_index    (node_index),
        .label_valid   (label_valid),
        .label         (label),
        .links_valid   (links_valid),
        .right_sibling (right_sibling),
        .child_count   (child_count),
        .anchor_valid  (anchor_valid),
        .anchor_number (anchor_number),
        .error         (error),
        .last          (last)
    );

    // 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---------------------------------------------------------------------
    // Forest model state: own copy of config, counters and bracket stacks
    // ---------------------------------------------------------------------
    logic [15:0] cfg_total     = 16'd1;
    logic        cfg_anchored  = 1'b0;
    logic        cfg_use_bases = 1'b1;

    logic [15:0] node_ctr   = 16'd0;
    int          nest_level = 0;
    logic [15:0] anchor_ctr = 16'd1;
    logic [15:0] pair_stack  [0:STACK_TOP] = '{default: 16'd0};
    logic [15:0] child_stack [0:STACK_TOP] = '{default: 16'd0};

    sym_req_t      pending_syms[$];   // requests waiting for the driver
    dbf_pkg::rec_t expected_recs[$];  // node records still owed by the DUT

    int mismatches   = 0;
    int drain_misses = 0;
    int gen_depth    = 0;        // nesting as the generator sees it
    int depth_cap    = 8;
    bit calm         = 1'b0;     // no gaps, no stalls

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic logic [15:0] rand_half();
        logic [31:0] r;
        r = $urandom;
        return r[15:0];
    endfunction

    // Work out the records one accepted request gives and queue them.
    task automatic predict_records(input logic [2:0] sym, input logic [7:0] base);
        dbf_pkg::rec_t rec;
        logic [7:0]    leaf;
        logic [15:0]   node;
        logic [15:0]   nxt;
        logic [15:0]   last_idx;
        leaf     = cfg_use_bases ? base : dbf_pkg::CHAR_B;
        node     = node_ctr;
        nxt      = node_ctr + 16'd1;
        last_idx = cfg_total - 16'd1;
        rec      = '0;
        rec.node_index = node;
        case (sym)
            dbf_pkg::KIND_DOT:
            begin
                rec.label_valid   = 1'b1;
                rec.label         = leaf;
                rec.links_valid   = 1'b1;
                rec.right_sibling = (node == last_idx) ? 16'd0 : nxt;
                rec.last          = 1'b1;
                expected_recs.insert(expected_recs.size(), rec);
                child_stack[nest_level] = child_stack[nest_level] + 16'd1;
                node_ctr = nxt;
            end
            dbf_pkg::KIND_OPEN:
            begin
                if (nest_level >= dbf_pkg::DEF_MAX_DEPTH)
                begin
                    rec.error = dbf_pkg::ERR_OVERFLOW;
                    rec.last  = 1'b1;
                    expected_recs.insert(expected_recs.size(), rec);
                end
                else
                begin
                    // pair node first, then its opening base
                    rec.label_valid = 1'b1;
                    rec.label       = dbf_pkg::CHAR_P;
                    expected_recs.insert(expected_recs.size(), rec);
                    child_stack[nest_level] = child_stack[nest_level] + 16'd1;
                    nest_level++;
                    pair_stack[nest_level]  = node;
                    child_stack[nest_level] = 16'd1;
                    rec               = '0;
                    rec.node_index    = nxt;
                    rec.label_valid   = 1'b1;
                    rec.label         = leaf;
                    rec.links_valid   = 1'b1;
                    rec.right_sibling = nxt + 16'd1;
                    rec.last          = 1'b1;
                    expected_recs.insert(expected_recs.size(), rec);
                    node_ctr = nxt + 16'd1;
                end
            end
            dbf_pkg::KIND_CLOSE:
            begin
                if (nest_level == 0)
                begin
                    rec.error = dbf_pkg::ERR_UNDERFLOW;
                    rec.last  = 1'b1;
                    expected_recs.insert(expected_recs.size(), rec);
                end
                else
                begin
                    // closing base, then the patched pair node
                    rec.label_valid = 1'b1;
                    rec.label       = leaf;
                    rec.links_valid = 1'b1;
                    expected_recs.insert(expected_recs.size(), rec);
                    rec               = '0;
                    rec.node_index    = pair_stack[nest_level];
                    rec.links_valid   = 1'b1;
                    rec.right_sibling = (node == last_idx) ? 16'd0 : nxt;
                    rec.child_count   = child_stack[nest_level] + 16'd1;
                    rec.last          = 1'b1;
                    expected_recs.insert(expected_recs.size(), rec);
                    nest_level--;
                    node_ctr = nxt;
                end
            end
            dbf_pkg::KIND_ANCHOR:
            begin
                if (cfg_anchored)
                begin
                    rec.anchor_valid  = 1'b1;
                    rec.anchor_number = anchor_ctr;
                    rec.last          = 1'b1;
                    expected_recs.insert(expected_recs.size(), rec);
                    anchor_ctr = anchor_ctr + 16'd1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Driver: bursts of requests from the pending queue with random gaps.
    // The payload only moves once the current request is taken.
    // ---------------------------------------------------------------------
    int       burst_left = 0;
    int       gap_left   = 0;
    sym_req_t next_req;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_records(kind, base_char);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 && !calm)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_syms.size() > 0)
                begin
                    next_req  = pending_syms.pop_front();
                    in_valid  <= 1'b1;
                    kind      <= next_req.sym;
                    base_char <= next_req.base;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 23);
                        gap_left   = $urandom_range(0, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver stall: short free runs and stalls, now and then a long stall
    // so that the command queue fills up behind it.
    // ---------------------------------------------------------------------
    int hold_left = 0;

    always @(posedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else if (hold_left > 0)
            hold_left--;
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            hold_left = $urandom_range(0, 10);
        end
        else
        begin
            out_stall <= 1'b1;
            if ($urandom_range(0, 15) == 0)
                hold_left = $urandom_range(8, 20);
            else
                hold_left = $urandom_range(0, 3);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: each taken record against the oldest expected one
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    dbf_pkg::rec_t want_rec;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_recs.size() == 0)
            begin
                mismatches++;
                $display("%0t: record expected none, got node %0h error %0h",
                         $time, node_index, error);
            end
            else
            begin
                want_rec = expected_recs.pop_front();
                check_field("node_index",    want_rec.node_index,    node_index);
                check_field("label_valid",   want_rec.label_valid,   label_valid);
                check_field("label",         want_rec.label,         label);
                check_field("links_valid",   want_rec.links_valid,   links_valid);
                check_field("right_sibling", want_rec.right_sibling, right_sibling);
                check_field("child_count",   want_rec.child_count,   child_count);
                check_field("anchor_valid",  want_rec.anchor_valid,  anchor_valid);
                check_field("anchor_number", want_rec.anchor_number, anchor_number);
                check_field("error",         want_rec.error,         error);
                check_field("last",          want_rec.last,          last);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic add_item(input logic [2:0] sym, input logic [7:0] base);
        sym_req_t req;
        req.sym  = sym;
        req.base = base;
        pending_syms.insert(pending_syms.size(), req);
        if (sym == dbf_pkg::KIND_OPEN && gen_depth < dbf_pkg::DEF_MAX_DEPTH)
            gen_depth++;
        else if (sym == dbf_pkg::KIND_CLOSE && gen_depth > 0)
            gen_depth--;
    endtask

    // Mostly balanced bracket text; a little noise and stray closes.
    task automatic add_random_item();
        int         roll;
        logic [1:0] spare;
        logic [2:0] sym;
        roll  = $urandom_range(0, 99);
        spare = 2'($urandom_range(0, 3));
        if (roll < 6)
            sym = KIND_FIRST_IGNORED | {1'b0, spare};
        else if (roll < 9)
            sym = (gen_depth == 0) ? dbf_pkg::KIND_CLOSE : dbf_pkg::KIND_DOT;
        else if (roll < 18)
            sym = dbf_pkg::KIND_ANCHOR;
        else if (roll < 48)
            sym = dbf_pkg::KIND_DOT;
        else if (roll < 74)
            sym = (gen_depth < depth_cap) ? dbf_pkg::KIND_OPEN : dbf_pkg::KIND_CLOSE;
        else
            sym = (gen_depth > 0) ? dbf_pkg::KIND_CLOSE : dbf_pkg::KIND_OPEN;
        add_item(sym, rand_byte());
    endtask

    // Register write; the model copy is updated on the accepting edge.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            dbf_pkg::CFG_TOTAL_NODES: cfg_total     = val;
            dbf_pkg::CFG_ANCHORED:    cfg_anchored  = val[0];
            dbf_pkg::CFG_USE_BASES:   cfg_use_bases = val[0];
            default:
            begin
            end
        endcase
    endtask

    // Single-bit registers get junk in the unused data bits.
    task automatic configure(input logic [15:0] total, input logic anch,
                             input logic bases);
        logic [15:0] junk;
        junk = rand_half();
        write_reg(dbf_pkg::CFG_TOTAL_NODES, total);
        write_reg(dbf_pkg::CFG_ANCHORED, {junk[15:1], anch});
        write_reg(dbf_pkg::CFG_USE_BASES, {junk[14:0], bases});
    endtask

    // Let every request go in and every record come out, then give the
    // block time to swallow any trailing requests that make no record.
    task automatic drain_block();
        int waited;
        waited = 0;
        while (pending_syms.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_recs.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_recs.size() != 0)
        begin
            drain_misses++;
            $display("%0t: %0d records expected, got none", $time, expected_recs.size());
            expected_recs.delete();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial
    begin
        logic [15:0] total_val;
        int          pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset config (one node, anchors off, real bases): first dot is the
        // last node, anchor and spare kinds dropped, stray close, one pair.
        add_item(dbf_pkg::KIND_DOT, 8'h00);
        add_item(dbf_pkg::KIND_ANCHOR, 8'hFF);
        for (int k = 0; k < 4; k++)
            add_item(KIND_FIRST_IGNORED | {1'b0, k[1:0]}, rand_byte());
        add_item(dbf_pkg::KIND_CLOSE, 8'hFF);
        add_item(dbf_pkg::KIND_OPEN, 8'hFF);
        add_item(dbf_pkg::KIND_DOT, 8'h41);
        add_item(dbf_pkg::KIND_CLOSE, 8'h7F);
        drain_block();

        // Anchors on, 'B' labels; total set so the outer pair is the last node.
        write_reg(CFG_UNUSED, rand_half());
        configure(node_ctr + 16'd8, 1'b1, 1'b0);
        add_item(dbf_pkg::KIND_ANCHOR, 8'h00);
        add_item(dbf_pkg::KIND_OPEN, 8'h43);
        add_item(dbf_pkg::KIND_ANCHOR, 8'h55);
        add_item(dbf_pkg::KIND_DOT, 8'hAA);
        add_item(dbf_pkg::KIND_OPEN, 8'h00);
        add_item(dbf_pkg::KIND_DOT, 8'hFF);
        add_item(dbf_pkg::KIND_CLOSE, 8'h47);
        add_item(dbf_pkg::KIND_CLOSE, 8'h55);
        add_item(dbf_pkg::KIND_ANCHOR, 8'hAA);
        drain_block();

        // Full depth: one open too many, then one close too many.
        configure(16'hFFFF, 1'b0, 1'b1);
        repeat (dbf_pkg::DEF_MAX_DEPTH + 1) add_item(dbf_pkg::KIND_OPEN, rand_byte());
        repeat (dbf_pkg::DEF_MAX_DEPTH + 1) add_item(dbf_pkg::KIND_CLOSE, rand_byte());
        drain_block();

        // Random phases, each with its own settings; total_nodes in two of the four
        // picks just ahead of the node counter so the last-node test comes up.
        for (int ph = 0; ph < 8; ph++)
        begin
            pick = $urandom_range(0, 3);
            case (pick)
                0:       total_val = node_ctr + 16'($urandom_range(1, 200));
                1:       total_val = 16'hFFFF;
                2:       total_val = 16'd1;
                default: total_val = node_ctr + 16'($urandom_range(1, 20));
            endcase
            configure(total_val, rand_byte() > 8'd90, rand_byte() > 8'd60);
            calm      = (ph == 3) || (ph == 6);
            depth_cap = (ph == 5) ? 40 : $urandom_range(2, 16);
            repeat (140) add_random_item();
            drain_block();
        end

        // Long pair: total_nodes 0 makes the all-ones index last; one pair
        // holds a run of dots and anchors back to back.
        calm = 1'b1;
        configure(16'd0, 1'b1, rand_byte() > 8'd127);
        add_item(dbf_pkg::KIND_OPEN, rand_byte());
        repeat (WRAP_PAIRS)
        begin
            add_item(dbf_pkg::KIND_DOT, rand_byte());
            add_item(dbf_pkg::KIND_ANCHOR, rand_byte());
        end
        add_item(dbf_pkg::KIND_CLOSE, rand_byte());
        drain_block();
        calm = 1'b0;

        if (mismatches == 0 && drain_misses == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
